/* design/pli_pkg.sv */
// Package for the positional list: capacity, widths, status codes and
// the per-cell shift control types. No dependencies.
`default_nettype none

package pli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned LETTER_W = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_NEW  = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [CMP_W-1:0] pos;
  } shift_ctrl_t;

endpackage

`default_nettype wire

/* design/pli_cell.sv */
// One slot of the list: holds an id and a name byte and loads from the
// new entry or from either neighbor. Depends on pli_pkg.
`default_nettype none

module pli_cell
  import pli_pkg::*;
(
  input  logic                clk_i,
  input  cell_op_e            op_i,
  input  logic [ID_W-1:0]     new_id_i,
  input  logic [LETTER_W-1:0] new_letter_i,
  input  logic [ID_W-1:0]     prev_id_i,
  input  logic [LETTER_W-1:0] prev_letter_i,
  input  logic [ID_W-1:0]     next_id_i,
  input  logic [LETTER_W-1:0] next_letter_i,
  output logic [ID_W-1:0]     id_o,
  output logic [LETTER_W-1:0] letter_o
);

  logic [ID_W-1:0]     id_q, id_d;
  logic [LETTER_W-1:0] letter_q, letter_d;

  always_comb begin
    case (op_i)
      CELL_LOAD_NEW: begin
        id_d     = new_id_i;
        letter_d = new_letter_i;
      end
      CELL_FROM_PREV: begin
        id_d     = prev_id_i;
        letter_d = prev_letter_i;
      end
      CELL_FROM_NEXT: begin
        id_d     = next_id_i;
        letter_d = next_letter_i;
      end
      default: begin
        id_d     = id_q;
        letter_d = letter_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    letter_q <= letter_d;
  end

  assign id_o     = id_q;
  assign letter_o = letter_q;

endmodule

`default_nettype wire

/* design/pli_ctrl.sv */
// Fill count register, status decision and shift control for the cell row.
// Depends on pli_pkg.
`default_nettype none

module pli_ctrl
  import pli_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             action_i,
  input  logic [POS_W-1:0] position_i,
  output status_e          status_o,
  output logic [CNT_W-1:0] count_next_o,
  output shift_ctrl_t      shift_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  status_e          status;

  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    count_d = count_q;
    if (action_i == ACT_INSERT) begin
      if (pos_ext > cnt_ext) begin
        status = ST_BADPOS;
      end else if (cnt_ext == CMP_W'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        status  = ST_OK;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else if (pos_ext >= cnt_ext) begin
        status = ST_BADPOS;
      end else begin
        status  = ST_OK;
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign status_o       = status;
  assign count_next_o   = count_d;
  assign shift_o.ins_en = accept_i && (status == ST_OK) && (action_i == ACT_INSERT);
  assign shift_o.rem_en = accept_i && (status == ST_OK) && (action_i == ACT_REMOVE);
  assign shift_o.pos    = pos_ext;

endmodule

`default_nettype wire

/* design/positional_list_insert_remove.sv */
// Positional list top level: control unit, row of slot cells, output register.
// Depends on pli_pkg, pli_ctrl and pli_cell.
// The result appears in the cycle after the input transfer.
// One item per cycle unless the output stalls; every cell shifts together.
// Reset: the entry count and the output valid clear; slot contents do not.
`default_nettype none

module positional_list_insert_remove
  import pli_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [LETTER_W-1:0]  entry_letter_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [OUT_CNT_W-1:0] entry_count_o
);

  logic                 accept;
  status_e              status;
  logic [CNT_W-1:0]     count_next;
  logic [CMP_W-1:0]     count_ext;
  shift_ctrl_t          shift;
  logic                 out_valid_q;
  status_e              status_q;
  logic [OUT_CNT_W-1:0] entry_count_q;

  logic [ID_W-1:0]      cell_id     [CAPACITY];
  logic [LETTER_W-1:0]  cell_letter [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  pli_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (action_i),
    .position_i   (position_i),
    .status_o     (status),
    .count_next_o (count_next),
    .shift_o      (shift)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ID_W-1:0]     prev_id, next_id;
    logic [LETTER_W-1:0] prev_letter, next_letter;
    cell_op_e            cell_op;

    if (k == 0) begin : g_head
      assign prev_id     = '0;
      assign prev_letter = '0;
    end else begin : g_body
      assign prev_id     = cell_id[k-1];
      assign prev_letter = cell_letter[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_id     = '0;
      assign next_letter = '0;
    end else begin : g_inner
      assign next_id     = cell_id[k+1];
      assign next_letter = cell_letter[k+1];
    end

    always_comb begin
      cell_op = CELL_HOLD;
      if (shift.ins_en) begin
        if (CMP_W'(k) == shift.pos) begin
          cell_op = CELL_LOAD_NEW;
        end else if (CMP_W'(k) > shift.pos) begin
          cell_op = CELL_FROM_PREV;
        end
      end else if (shift.rem_en && (CMP_W'(k) >= shift.pos)) begin
        cell_op = CELL_FROM_NEXT;
      end
    end

    pli_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op),
      .new_id_i      (entry_id_i),
      .new_letter_i  (entry_letter_i),
      .prev_id_i     (prev_id),
      .prev_letter_i (prev_letter),
      .next_id_i     (next_id),
      .next_letter_i (next_letter),
      .id_o          (cell_id[k]),
      .letter_o      (cell_letter[k])
    );
  end

  assign count_ext = CMP_W'(count_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status;
      entry_count_q <= count_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

/* design/pli_checker.sv */
// Port-level checker for the positional list and its bind to the top level.
// Depends on pli_pkg.
`default_nettype none

module pli_checker
  import pli_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 action_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           status_o,
  input logic [OUT_CNT_W-1:0] entry_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)
      && $stable(entry_count_o)))
    else $error("Result changed before its transfer.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("No result after an input transfer.");

  a_remove_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_REMOVE) |=> (status_o != ST_FULL))
    else $error("Remove reported a full list.");

  a_insert_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_INSERT) |=> (status_o != ST_EMPTY))
    else $error("Insert reported an empty list.");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (entry_count_o == '0))
    else $error("Empty status with a nonzero count.");

endmodule

bind positional_list_insert_remove pli_checker u_pli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire
